// File: src/ceq_pkg.sv
// ----------------------------------------------------------------------------
// ceq_pkg
// Types and constants shared by the coalescing event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

	localparam int ID_W  = 4;
	localparam int PAY_W = 8;
	localparam int CNT_W = 5;
	// wide enough to hold any source count up to 256
	localparam int EXT_W = 9;

	typedef enum logic {
		ACT_POST = 1'b0,
		ACT_TAKE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RING,
		ST_PAY
	} state_t;

	typedef struct packed {
		action_t            action;
		logic [ID_W-1:0]    source_id;
		logic [PAY_W-1:0]   payload;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]    out_source;
		logic [PAY_W-1:0]   out_payload;
		logic               queue_was_empty;
		logic               merged;
		logic [CNT_W-1:0]   pending_count;
	} rsp_t;

endpackage

// File: src/coalescing_event_queue_unit.sv
// Post, or take on an empty queue: result strobed in the cycle after the accept,
// busy stays low, so one such transaction can be started every cycle.
// Take of a pending source: busy is high through the ring read (ST_RING) and the
// payload read (ST_PAY), and the result is registered as ST_PAY ends.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset clears pending flags, head, tail and count; the RAMs are not cleared.
// ----------------------------------------------------------------------------
// coalescing_event_queue_unit
// FIFO of pending event sources that merges repeated posts of one source.
// ----------------------------------------------------------------------------
module coalescing_event_queue_unit #(
	parameter int NUM_SOURCES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ceq_pkg::req_t  req,
	output logic           rsp_valid,
	output ceq_pkg::rsp_t  rsp
);

	localparam int IDX_W = $clog2(NUM_SOURCES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);
	localparam logic [ceq_pkg::EXT_W-1:0] NUM_EXT = ceq_pkg::EXT_W'(NUM_SOURCES);

	ceq_pkg::state_t state_q, state_nxt;

	logic [IDX_W-1:0]             head_q, tail_q;
	logic [ceq_pkg::CNT_W-1:0]    count_q;
	logic [NUM_SOURCES-1:0]       pending_q;
	logic [ceq_pkg::ID_W-1:0]     id_q;
	logic                         rsp_valid_q;
	ceq_pkg::rsp_t                rsp_q;

	logic [ceq_pkg::EXT_W-1:0]    src_ext, ring_ext;
	logic [IDX_W-1:0]             src_idx, ring_idx;
	logic                         src_ok, post_fire, take_fire, take_hit, enqueue, merge;
	logic [ceq_pkg::ID_W-1:0]     ring_rdata;
	logic [ceq_pkg::PAY_W-1:0]    pay_rdata;

	assign busy      = (state_q != ceq_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		src_ext   = ceq_pkg::EXT_W'(req.source_id);
		src_idx   = src_ext[IDX_W-1:0];
		src_ok    = (src_ext < NUM_EXT);
		ring_ext  = ceq_pkg::EXT_W'(ring_rdata);
		ring_idx  = ring_ext[IDX_W-1:0];
		post_fire = start && !busy && (req.action == ceq_pkg::ACT_POST);
		take_fire = start && !busy && (req.action == ceq_pkg::ACT_TAKE);
		take_hit  = take_fire && (count_q != '0);
		merge     = post_fire && src_ok && pending_q[src_idx];
		enqueue   = post_fire && src_ok && !pending_q[src_idx]
			&& (ceq_pkg::EXT_W'(count_q) < NUM_EXT);
	end

	// per-source payload, written on every valid post
	ceq_ram #(
		.WIDTH(ceq_pkg::PAY_W),
		.DEPTH(NUM_SOURCES)
	) u_pay_ram (
		.clk   (clk),
		.we    (post_fire && src_ok),
		.waddr (src_idx),
		.wdata (req.payload),
		.raddr (ring_idx),
		.rdata (pay_rdata)
	);

	// order ring of queued source ids
	ceq_ram #(
		.WIDTH(ceq_pkg::ID_W),
		.DEPTH(NUM_SOURCES)
	) u_ring_ram (
		.clk   (clk),
		.we    (enqueue),
		.waddr (tail_q),
		.wdata (req.source_id),
		.raddr (head_q),
		.rdata (ring_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ceq_pkg::ST_IDLE: begin
				if (take_hit) begin
					state_nxt = ceq_pkg::ST_RING;
				end
			end
			ceq_pkg::ST_RING: state_nxt = ceq_pkg::ST_PAY;
			ceq_pkg::ST_PAY:  state_nxt = ceq_pkg::ST_IDLE;
			default:          state_nxt = ceq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ceq_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pending_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= post_fire || (take_fire && !take_hit)
				|| (state_q == ceq_pkg::ST_PAY);
			if (enqueue) begin
				pending_q[src_idx] <= 1'b1;
				tail_q             <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
				count_q            <= count_q + 1'b1;
			end
			// head id is on the ring read port here
			if (state_q == ceq_pkg::ST_RING) begin
				pending_q[ring_idx] <= 1'b0;
				head_q              <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
				count_q             <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ceq_pkg::ST_RING) begin
			id_q <= ring_rdata;
		end
		if (post_fire) begin
			rsp_q.out_source      <= req.source_id;
			rsp_q.out_payload     <= '0;
			rsp_q.queue_was_empty <= 1'b0;
			rsp_q.merged          <= merge;
			rsp_q.pending_count   <= enqueue ? count_q + 1'b1 : count_q;
		end else if (take_fire && !take_hit) begin
			rsp_q.out_source      <= '0;
			rsp_q.out_payload     <= '0;
			rsp_q.queue_was_empty <= 1'b1;
			rsp_q.merged          <= 1'b0;
			rsp_q.pending_count   <= count_q;
		end else if (state_q == ceq_pkg::ST_PAY) begin
			rsp_q.out_source      <= id_q;
			rsp_q.out_payload     <= pay_rdata;
			rsp_q.queue_was_empty <= 1'b0;
			rsp_q.merged          <= 1'b0;
			rsp_q.pending_count   <= count_q;
		end
	end

endmodule

// File: src/ceq_ram.sv
// ----------------------------------------------------------------------------
// ceq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ceq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: bench/coalescing_event_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coalescing_event_queue_unit_tb
// Drives posts and takes into the coalescing event queue through the start/busy
// handshake. A behavioral copy of the queue (pending flags, payloads, arrival
// ring) predicts every result, which is compared field by field when strobed.
// ----------------------------------------------------------------------------
module coalescing_event_queue_unit_tb;

	localparam int NUM_SRC        = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_GAP        = 40;
	localparam int REQ_W          = $bits(ceq_pkg::req_t);

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	ceq_pkg::req_t  req;
	logic           rsp_valid;
	ceq_pkg::rsp_t  rsp;

	coalescing_event_queue_unit #(
		.NUM_SOURCES(NUM_SRC)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// behavioral copy of the queue
	logic                      pend_flag    [NUM_SRC];
	logic [ceq_pkg::PAY_W-1:0] latest_pay   [NUM_SRC];
	logic [ceq_pkg::ID_W-1:0]  arrival_ring [NUM_SRC];
	int                        ring_head;
	int                        ring_tail;
	int                        model_fill;

	ceq_pkg::rsp_t outcome_q [$];

	int errors;
	int items_sent;
	int idle_pct;
	int stall_cycles = 0;
	int post_cnt, merge_cnt, take_cnt, empty_cnt, full_cnt;

	function ceq_pkg::rsp_t predict_event(input ceq_pkg::req_t r);
		ceq_pkg::rsp_t o;
		int            id;
		o = '0;
		if (r.action == ceq_pkg::ACT_POST) begin
			post_cnt++;
			o.out_source = r.source_id;
			if (r.source_id < NUM_SRC) begin
				latest_pay[r.source_id] = r.payload;
				if (pend_flag[r.source_id]) begin
					o.merged = 1'b1;
					merge_cnt++;
				end else if (model_fill < NUM_SRC) begin
					pend_flag[r.source_id] = 1'b1;
					arrival_ring[ring_tail] = r.source_id;
					ring_tail = (ring_tail + 1) % NUM_SRC;
					model_fill++;
				end
			end
		end else begin
			take_cnt++;
			if (model_fill == 0) begin
				o.queue_was_empty = 1'b1;
				empty_cnt++;
			end else begin
				id = arrival_ring[ring_head] % NUM_SRC;
				ring_head = (ring_head + 1) % NUM_SRC;
				model_fill--;
				pend_flag[id] = 1'b0;
				o.out_source = ceq_pkg::ID_W'(id);
				o.out_payload = latest_pay[id];
			end
		end
		if (model_fill == NUM_SRC)
			full_cnt++;
		o.pending_count = ceq_pkg::CNT_W'(model_fill);
		return o;
	endfunction

	task automatic report_error(input string what);
		$display("ERROR at %0t: %s", $time, what);
		errors++;
	endtask

	// one transaction; start stays high after acceptance for back-to-back items
	task automatic send_event(input ceq_pkg::req_t item);
		int            gap;
		ceq_pkg::req_t noise;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP)
			gap++;
		if (gap > 0) begin
			noise = ceq_pkg::req_t'(REQ_W'($urandom));
			@(negedge clk);
			start <= 1'b0;
			req   <= noise;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		outcome_q.push_back(predict_event(item));
		items_sent++;
	endtask

	task automatic post_event(input logic [ceq_pkg::ID_W-1:0] id,
		input logic [ceq_pkg::PAY_W-1:0] pay);
		ceq_pkg::req_t r;
		r.action    = ceq_pkg::ACT_POST;
		r.source_id = id;
		r.payload   = pay;
		send_event(r);
	endtask

	// source and payload are don't-care on a take, so they carry noise
	task automatic take_event();
		ceq_pkg::req_t r;
		r.action    = ceq_pkg::ACT_TAKE;
		r.source_id = ceq_pkg::ID_W'($urandom_range(15));
		r.payload   = ceq_pkg::PAY_W'($urandom_range(255));
		send_event(r);
	endtask

	function automatic ceq_pkg::req_t mixed_item();
		ceq_pkg::req_t r;
		int            take_pct;
		take_pct = (model_fill == 0) ? 10 : (model_fill == NUM_SRC) ? 70 : 40;
		r.action = ($urandom_range(99) < take_pct) ? ceq_pkg::ACT_TAKE : ceq_pkg::ACT_POST;
		// half the posts come from a few hot sources so merges are common
		r.source_id = ceq_pkg::ID_W'($urandom_range(1) ? $urandom_range(15)
			: $urandom_range(15, 12));
		r.payload   = ceq_pkg::PAY_W'($urandom_range(255));
		return r;
	endfunction

	task automatic test_empty_take();
		ceq_pkg::req_t r;
		r = '{action: ceq_pkg::ACT_TAKE, source_id: 4'h0, payload: 8'h00};
		send_event(r);
		r = '{action: ceq_pkg::ACT_TAKE, source_id: 4'hf, payload: 8'hff};
		send_event(r);
	endtask

	task automatic test_post_merge();
		post_event(4'h0, 8'h00);
		post_event(4'hf, 8'hff);
		post_event(4'h0, 8'ha5);
		post_event(4'hf, 8'h5a);
		post_event(4'h7, 8'h80);
		take_event();
		take_event();
		post_event(4'h0, 8'h01);
		take_event();
		take_event();
		take_event();
	endtask

	task automatic test_random_phase(input int pct, input int quota);
		int                       stop_at;
		int                       n;
		int                       k;
		int                       j;
		logic [ceq_pkg::ID_W-1:0] tmp;
		logic [ceq_pkg::ID_W-1:0] order [NUM_SRC];
		idle_pct = pct;
		stop_at  = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 30) begin
				// burst of distinct sources, often filling the queue, then drain to empty, sometimes past it
				for (k = 0; k < NUM_SRC; k++)
					order[k] = ceq_pkg::ID_W'(k);
				for (k = NUM_SRC - 1; k > 0; k--) begin
					j = $urandom_range(k);
					tmp = order[k];
					order[k] = order[j];
					order[j] = tmp;
				end
				n = ($urandom_range(2) == 0) ? NUM_SRC : $urandom_range(15, 4);
				for (k = 0; k < n; k++)
					post_event(order[k], ceq_pkg::PAY_W'($urandom_range(255)));
				repeat ($urandom_range(4))
					post_event(ceq_pkg::ID_W'($urandom_range(15)),
						ceq_pkg::PAY_W'($urandom_range(255)));
				n = model_fill + $urandom_range(2);
				repeat (n) take_event();
			end else begin
				repeat ($urandom_range(40, 10)) send_event(mixed_item());
			end
		end
	endtask

	always @(posedge clk) begin
		ceq_pkg::rsp_t want;
		if (arst_n && rsp_valid) begin
			if (outcome_q.size() == 0) begin
				report_error("result strobed with no transaction outstanding");
			end else begin
				want = outcome_q.pop_front();
				if (rsp.out_source !== want.out_source)
					report_error($sformatf("out_source %0h, expected %0h",
						rsp.out_source, want.out_source));
				if (rsp.out_payload !== want.out_payload)
					report_error($sformatf("out_payload %0h, expected %0h",
						rsp.out_payload, want.out_payload));
				if (rsp.queue_was_empty !== want.queue_was_empty)
					report_error($sformatf("queue_was_empty %0b, expected %0b",
						rsp.queue_was_empty, want.queue_was_empty));
				if (rsp.merged !== want.merged)
					report_error($sformatf("merged %0b, expected %0b",
						rsp.merged, want.merged));
				if (rsp.pending_count !== want.pending_count)
					report_error($sformatf("pending_count %0d, expected %0d",
						rsp.pending_count, want.pending_count));
			end
		end
	end

	// ends the run when neither a transaction nor a result moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || rsp_valid)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", outcome_q.size());
			$display("coalescing_event_queue_unit regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		errors       = 0;
		items_sent   = 0;
		idle_pct     = 0;
		post_cnt     = 0;
		merge_cnt    = 0;
		take_cnt     = 0;
		empty_cnt    = 0;
		full_cnt     = 0;
		ring_head    = 0;
		ring_tail    = 0;
		model_fill   = 0;
		for (int i = 0; i < NUM_SRC; i++) begin
			pend_flag[i]    = 1'b0;
			latest_pay[i]   = '0;
			arrival_ring[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_take();
		test_post_merge();
		test_random_phase(0, 390);
		test_random_phase(71, 390);
		test_random_phase(11, 390);
		test_random_phase(0, 370);

		@(negedge clk);
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("covered %0d transactions: %0d posts (%0d merged), %0d takes (%0d on empty)",
			items_sent, post_cnt, merge_cnt, take_cnt, empty_cnt);
		$display("queue left full by %0d transactions, %0d mismatches", full_cnt, errors);
		if (errors == 0)
			$display("coalescing_event_queue_unit regression: pass");
		else
			$display("coalescing_event_queue_unit regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
src/ceq_pkg.sv
src/ceq_ram.sv
src/coalescing_event_queue_unit.sv
bench/coalescing_event_queue_unit_tb.sv
